// ===== rtl/bdau_pkg.sv =====
// ----------------------------------------------------------------------------
// bdau_pkg
// Shared types, constants and elaboration helpers for the binary to decimal
// ASCII unit.
// ----------------------------------------------------------------------------
package bdau_pkg;

  localparam int VALUE_W        = 32;
  localparam int DIGIT_W        = 6;
  localparam int BCD_W          = 4;
  localparam int DEF_VALUE_BITS = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [BCD_W-1:0]   BCD_FIVE   = 4'd5;
  localparam logic [BCD_W-1:0]   BCD_THREE  = 4'd3;

  // One queued item: the masked value and whether it is zero.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_zero;
  } bdau_item_t;

  // Only the low VALUE_W bits of the input field can be nonzero.
  function automatic int eff_bits(input int value_bits);
    return (value_bits < VALUE_W) ? value_bits : VALUE_W;
  endfunction

  // Decimal digits of 2**bits - 1; 1233/4096 approximates log10(2).
  function automatic int num_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  function automatic logic [VALUE_W-1:0] value_mask(input int bits);
    logic [VALUE_W-1:0] m;
    for (int i = 0; i < VALUE_W; i++) begin
      m[i] = (i < bits);
    end
    return m;
  endfunction

endpackage

// ===== rtl/bdau_if.sv =====
// ----------------------------------------------------------------------------
// bdau_if
// Valid/ready channel interfaces for the input values and the ASCII digits.
// ----------------------------------------------------------------------------
interface bdau_in_if import bdau_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface bdau_out_if import bdau_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_char;
  logic               last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== rtl/bdau_front.sv =====
// ----------------------------------------------------------------------------
// bdau_front
// Input stage: takes a value, masks it to the converted width and tags the
// zero case so the converter can skip the shift phase for it.
// ----------------------------------------------------------------------------
module bdau_front import bdau_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  bdau_in_if.sink       in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output bdau_item_t    push_item
);

  localparam int                 EFF_BITS = eff_bits(VALUE_BITS);
  localparam logic [VALUE_W-1:0] MASK     = value_mask(EFF_BITS);

  logic               vld_r;
  bdau_item_t         item_r;
  logic [VALUE_W-1:0] masked;

  assign masked      = in_ch.value & MASK;
  assign in_ch.ready = !vld_r || push_ready;
  assign push_valid  = vld_r;
  assign push_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.value   <= masked;
      item_r.is_zero <= (masked == '0);
    end
  end

endmodule

// ===== rtl/bdau_queue.sv =====
// ----------------------------------------------------------------------------
// bdau_queue
// Short FIFO between the input stage and the converter.
// ----------------------------------------------------------------------------
module bdau_queue import bdau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  bdau_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output bdau_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bdau_item_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/bdau_back.sv =====
// ----------------------------------------------------------------------------
// bdau_back
// Serial double-dabble converter followed by a digit emitter that drops
// leading zeros and drives the registered output channel.
// ----------------------------------------------------------------------------
module bdau_back import bdau_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  bdau_item_t  pop_item,
  bdau_out_if.source  out_ch
);

  localparam int EFF_BITS = eff_bits(VALUE_BITS);
  localparam int DIGITS   = num_digits(EFF_BITS);
  localparam int DEC_W    = DIGITS * BCD_W;
  localparam int CNT_W    = $clog2(EFF_BITS + 1);
  localparam int IDX_W    = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic [EFF_BITS-1:0] sh_r;
  logic [DEC_W-1:0]    bcd_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    idx_r;
  logic                started_r;
  logic                out_vld_r;
  logic [DIGIT_W-1:0]  out_char_r;
  logic                out_last_r;

  logic [DEC_W-1:0]    bcd_adj;
  logic [DEC_W-1:0]    bcd_shift;
  logic [BCD_W-1:0]    top_digit;
  logic                out_free;
  logic                final_digit;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*BCD_W +: BCD_W] = (bcd_r[i*BCD_W +: BCD_W] >= BCD_FIVE) ?
                                  bcd_r[i*BCD_W +: BCD_W] + BCD_THREE :
                                  bcd_r[i*BCD_W +: BCD_W];
    end
  end

  assign bcd_shift   = {bcd_adj[DEC_W-2:0], sh_r[EFF_BITS-1]};
  assign top_digit   = bcd_r[DEC_W-1 -: BCD_W];
  assign out_free    = !out_vld_r || out_ch.ready;
  assign final_digit = (idx_r == IDX_W'(1));
  assign pop_ready   = (state_r == ST_IDLE);

  assign out_ch.valid      = out_vld_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            sh_r      <= pop_item.value[EFF_BITS-1:0];
            bcd_r     <= '0;
            cnt_r     <= CNT_W'(EFF_BITS);
            started_r <= 1'b0;
            // A zero value goes straight to a single '0' digit.
            if (pop_item.is_zero) begin
              idx_r   <= IDX_W'(1);
              state_r <= ST_EMIT;
            end else begin
              idx_r   <= IDX_W'(DIGITS);
              state_r <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          bcd_r <= bcd_shift;
          sh_r  <= sh_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Leading zeros are shifted out without producing a character.
          if (!started_r && (top_digit == '0) && !final_digit) begin
            bcd_r <= bcd_r << BCD_W;
            idx_r <= idx_r - 1'b1;
          end else if (out_free) begin
            out_vld_r  <= 1'b1;
            out_char_r <= ASCII_ZERO + DIGIT_W'(top_digit);
            out_last_r <= final_digit;
            started_r  <= 1'b1;
            bcd_r      <= bcd_r << BCD_W;
            idx_r      <= idx_r - 1'b1;
            if (final_digit) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// The converter takes one value at a time: it accepts the next value only after the
// last digit of the previous one is issued, and the queue holds waiting values.
// A nonzero value goes through min(VALUE_BITS, 32) shift steps in the serial BCD
// shifter; a zero value skips them. The first digit comes after the input register,
// the queue, the load and the shift phase; each leading zero takes an emit step.
// Reset: synchronous, active low; clears the queue, the converter and the output.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts unsigned binary values to ASCII decimal text, most significant
// digit first, without leading zeros, marking the final digit with last.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit import bdau_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  bdau_in_if.sink    in_ch,
  bdau_out_if.source out_ch
);

  logic       push_valid;
  logic       push_ready;
  bdau_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  bdau_item_t pop_item;

  bdau_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  bdau_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  bdau_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule
